@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of this block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the reset is applied.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Assertion that is checked in every cycle, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ rtl/mlws_pkg.sv @@
// Package of the minimum length window sum block: field widths, beat types
// and the command codes of the shared sum unit. Depends on nothing.
package mlws_pkg;

  localparam int VALUE_W         = 16;
  localparam int TARGET_W        = 26;
  localparam int LEN_W           = 11;
  localparam int DEFAULT_MAX_LEN = 1024;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 26'd1;

  // Commands of the shared add/subtract unit.
  localparam logic [1:0] ACC_HOLD  = 2'd0;
  localparam logic [1:0] ACC_ADD   = 2'd1;
  localparam logic [1:0] ACC_SUB   = 2'd2;
  localparam logic [1:0] ACC_CLEAR = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] sample_value;
    logic               end_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] shortest_length;
    logic             length_overflow;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [VALUE_W-1:0] operand;
  } acc_cmd_t;

endpackage

@@ rtl/min_length_window_sum_unit.sv @@
// Minimum length window sum: shortest run of values whose sum reaches the target.
// An accepted value goes through check and finish, an ignored one straight to finish;
// the shrink loop reads the window RAM and then subtracts on the one shared adder.
// A final result is registered in the finish state, which stalls while an older
// result still waits. Reset (synchronous, active low) clears the sequence state and sets
// the target to 1; the window RAM is not cleared, since only written entries are ever read.
module min_length_window_sum_unit #(
  parameter int MAX_LEN = mlws_pkg::DEFAULT_MAX_LEN
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mlws_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mlws_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [mlws_pkg::TARGET_W-1:0] cfg_data
);
  import mlws_pkg::*;

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int SUM_W = VALUE_W + CNT_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_SUB    = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    oldest_r, oldest_nxt;
  logic [IDX_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    best_r, best_nxt;
  logic [CNT_W-1:0]    items_r, items_nxt;
  logic                ovf_r, ovf_nxt;
  logic                last_r, last_nxt;
  logic [TARGET_W-1:0] target_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic               in_fire;
  logic               ram_we;
  logic               ram_re;
  logic [VALUE_W-1:0] ram_rdata;
  acc_cmd_t           acc_cmd;
  logic               sum_ge;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
    ring_next = (pos == IDX_W'(MAX_LEN - 1)) ? '0 : pos + 1'b1;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    best_nxt      = best_r;
    items_nxt     = items_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    acc_cmd.op      = ACC_HOLD;
    acc_cmd.operand = ram_rdata;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          last_nxt = in_data.end_of_sequence;
          if (items_r >= CNT_W'(MAX_LEN)) begin
            // The sequence already holds MAX_LEN values: the value is dropped.
            ovf_nxt   = 1'b1;
            state_nxt = S_FINISH;
          end else begin
            ram_we          = 1'b1;
            tail_nxt        = ring_next(tail_r);
            count_nxt       = count_r + 1'b1;
            items_nxt       = items_r + 1'b1;
            acc_cmd.op      = ACC_ADD;
            acc_cmd.operand = in_data.sample_value;
            state_nxt       = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if ((count_r != '0) && sum_ge) begin
          if ((best_r == '0) || (count_r < best_r)) begin
            best_nxt = count_r;
          end
          ram_re    = 1'b1;
          state_nxt = S_SUB;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SUB: begin
        acc_cmd.op = ACC_SUB;
        oldest_nxt = ring_next(oldest_r);
        count_nxt  = count_r - 1'b1;
        state_nxt  = S_CHECK;
      end
      S_FINISH: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.shortest_length = LEN_W'(best_r);
          out_data_nxt.length_overflow = ovf_r;
          oldest_nxt = '0;
          tail_nxt   = '0;
          count_nxt  = '0;
          best_nxt   = '0;
          items_nxt  = '0;
          ovf_nxt    = 1'b0;
          acc_cmd.op = ACC_CLEAR;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      best_r      <= '0;
      items_r     <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      target_r    <= TARGET_RESET;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      best_r      <= best_nxt;
      items_r     <= items_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        target_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mlws_window_ram #(
    .DEPTH(MAX_LEN)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail_r),
    .wdata(in_data.sample_value),
    .re   (ram_re),
    .raddr(oldest_r),
    .rdata(ram_rdata)
  );

  mlws_sum_unit #(
    .SUM_W(SUM_W)
  ) u_sum (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (acc_cmd),
    .target(target_r),
    .sum_ge(sum_ge)
  );

endmodule

@@ rtl/mlws_window_ram.sv @@
// Ring buffer storage of the current window: one write and one registered
// read port. Depends on mlws_pkg for the value width.
module mlws_window_ram #(
  parameter int DEPTH = mlws_pkg::DEFAULT_MAX_LEN,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [mlws_pkg::VALUE_W-1:0] wdata,
  input  logic                         re,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [mlws_pkg::VALUE_W-1:0] rdata
);
  import mlws_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mlws_sum_unit.sv @@
// Shared running sum unit: one adder/subtractor on the window sum and the
// compare against the target. Depends on mlws_pkg for commands and widths.
module mlws_sum_unit #(
  parameter int SUM_W = mlws_pkg::VALUE_W + 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mlws_pkg::acc_cmd_t            cmd,
  input  logic [mlws_pkg::TARGET_W-1:0] target,
  output logic                          sum_ge
);
  import mlws_pkg::*;

  localparam int CMP_W = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;

  logic [SUM_W-1:0] sum_r, sum_nxt;

  always_comb begin
    sum_nxt = sum_r;
    unique case (cmd.op)
      ACC_HOLD:  sum_nxt = sum_r;
      ACC_ADD:   sum_nxt = sum_r + SUM_W'(cmd.operand);
      ACC_SUB:   sum_nxt = sum_r - SUM_W'(cmd.operand);
      ACC_CLEAR: sum_nxt = '0;
      default:   sum_nxt = sum_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_ge = CMP_W'(sum_r) >= CMP_W'(target);

endmodule

@@ rtl/mlws_checker.sv @@
// Port level checks of the minimum length window sum block, bound to its top.
// Depends on mlws_pkg for the beat types and on assert_macros.svh.
`include "assert_macros.svh"

module mlws_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input mlws_pkg::in_item_t            in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input mlws_pkg::out_item_t           out_data
);
  import mlws_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // A stalled result beat keeps its payload.
  `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // A stalled input beat keeps its payload.
  `ASSERT_RST(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable(in_data))

  // Reset drops any pending result.
  `ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid)

  // After taking a beat the block is busy in the next cycle.
  `ASSERT_RST(a_busy_after_beat, clk, rst_n, in_beat |=> !in_ready)

  // A new result only appears as the block leaves a busy cycle.
  `ASSERT_RST(a_result_cause, clk, rst_n, $rose(out_valid) |-> !$past(in_ready))

endmodule

bind min_length_window_sum_unit mlws_checker u_mlws_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
